// File: rtl/bdfc_pkg.sv
`default_nettype none

package bdfc_pkg;

  localparam int unsigned NUM_LANES  = 4;
  localparam int unsigned NUM_PIXELS = 4;
  localparam int unsigned SUM_W      = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 2;

  // Reciprocal of 3 in 11 fractional bits; exact for dividends below 2048.
  localparam int unsigned RECIP3_SHIFT = 11;
  localparam logic [10:0] RECIP3       = 11'd683;

  typedef enum logic [1:0] {
    FMT_GRAY = 2'd0,
    FMT_RGB  = 2'd1,
    FMT_RGBA = 2'd2,
    FMT_LAB  = 2'd3
  } fmt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_FORMAT = 2'd0,
    CFG_DEST_FORMAT   = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] top_left;
    logic [31:0] top_right;
    logic [31:0] bottom_left;
    logic [31:0] bottom_right;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       format_error;
  } out_beat_t;

  typedef struct packed {
    fmt_t src;
    fmt_t dst;
  } fmt_cfg_t;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

endpackage

`default_nettype wire

// File: rtl/box_downsample_2x2_format_convert_unit.sv
// 2x2 box downsampler with pixel format conversion.
// Input channel: one beat carries the four packed pixels of a 2x2 block
// (byte0 red/gray, byte1 green, byte2 blue, byte3 alpha). Output channel:
// one beat carries the reduced pixel and a format error flag. Both channels
// use valid/stall; a beat moves when valid is high and stall is low.
// Configuration: cfg_index 0 writes the source format, 1 the destination
// format; other indexes are ignored. cfg_ready is always high. Write the
// formats only while no block is in flight.
// Four channel lanes register their byte sums, then the merge stage forms
// the result into the output register. Throughput is one block per cycle
// while the receiver does not stall, set by the two-stage pipeline.
// Reset (rst_n low, synchronous) empties the pipeline and sets both formats
// to rgba8. When the receiver stalls, the output beat holds; one more block
// waits in the lane stage, after which in_stall rises.
`default_nettype none

module box_downsample_2x2_format_convert_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire bdfc_pkg::in_beat_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output bdfc_pkg::out_beat_t                      out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [bdfc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bdfc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  bdfc_pkg::fmt_cfg_t  cfg_r;
  logic                s1_valid_r;
  logic                out_valid_r;
  bdfc_pkg::out_beat_t out_data_r;
  bdfc_pkg::out_beat_t merged;
  logic                s1_load;
  logic                out_load;

  logic [bdfc_pkg::NUM_LANES-1:0][bdfc_pkg::SUM_W-1:0] lane_sums;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src <= bdfc_pkg::FMT_RGBA;
      cfg_r.dst <= bdfc_pkg::FMT_RGBA;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bdfc_pkg::CFG_SOURCE_FORMAT: cfg_r.src <= bdfc_pkg::fmt_t'(cfg_wdata);
        bdfc_pkg::CFG_DEST_FORMAT:   cfg_r.dst <= bdfc_pkg::fmt_t'(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    out_load = s1_valid_r && (!out_valid_r || !out_stall);
    in_stall = s1_valid_r && !out_load;
    s1_load  = in_valid && !in_stall;
  end

  for (genvar k = 0; k < bdfc_pkg::NUM_LANES; k++) begin : g_lane
    logic [bdfc_pkg::NUM_PIXELS-1:0][7:0] lane_bytes;

    assign lane_bytes[0] = in_data.top_left[8*k +: 8];
    assign lane_bytes[1] = in_data.top_right[8*k +: 8];
    assign lane_bytes[2] = in_data.bottom_left[8*k +: 8];
    assign lane_bytes[3] = in_data.bottom_right[8*k +: 8];

    bdfc_lane u_lane (
      .clk     (clk),
      .load    (s1_load),
      .bytes_i (lane_bytes),
      .sum_r   (lane_sums[k])
    );
  end

  bdfc_merge u_merge (
    .sums_i (lane_sums),
    .cfg_i  (cfg_r),
    .beat_o (merged)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (out_load) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= merged;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/bdfc_lane.sv
`default_nettype none

module bdfc_lane (
  input  wire logic                               clk,
  input  wire logic                               load,
  input  wire logic [bdfc_pkg::NUM_PIXELS-1:0][7:0] bytes_i,
  output logic      [bdfc_pkg::SUM_W-1:0]         sum_r
);

  logic [bdfc_pkg::SUM_W-1:0] sum_nxt;

  always_comb begin
    sum_nxt = ({2'b00, bytes_i[0]} + {2'b00, bytes_i[1]})
            + ({2'b00, bytes_i[2]} + {2'b00, bytes_i[3]});
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bdfc_merge.sv
`default_nettype none

module bdfc_merge (
  input  wire logic [bdfc_pkg::NUM_LANES-1:0][bdfc_pkg::SUM_W-1:0] sums_i,
  input  wire bdfc_pkg::fmt_cfg_t                                  cfg_i,
  output bdfc_pkg::out_beat_t                                      beat_o
);

  logic [7:0]  avg_r, avg_g, avg_b, avg_a;
  logic [11:0] rgb_sum;
  logic [9:0]  rgb_quarter;
  logic [20:0] gray_prod;
  logic [7:0]  gray_val;

  always_comb begin
    avg_r = sums_i[0][9:2];
    avg_g = sums_i[1][9:2];
    avg_b = sums_i[2][9:2];
    avg_a = sums_i[3][9:2];

    // Sum / 12 is taken as (sum / 4) / 3, the divide by 3 as a reciprocal multiply.
    rgb_sum     = {2'b00, sums_i[0]} + {2'b00, sums_i[1]} + {2'b00, sums_i[2]};
    rgb_quarter = rgb_sum[11:2];
    gray_prod   = {11'd0, rgb_quarter} * {10'd0, bdfc_pkg::RECIP3};
    gray_val    = gray_prod[bdfc_pkg::RECIP3_SHIFT +: 8];

    beat_o = '0;
    if (cfg_i.src == bdfc_pkg::FMT_LAB || cfg_i.dst == bdfc_pkg::FMT_LAB) begin
      beat_o.format_error = 1'b1;
    end else if (cfg_i.src == bdfc_pkg::FMT_GRAY) begin
      beat_o.out_red = avg_r;
      if (cfg_i.dst != bdfc_pkg::FMT_GRAY) begin
        beat_o.out_green = avg_r;
        beat_o.out_blue  = avg_r;
        if (cfg_i.dst == bdfc_pkg::FMT_RGBA) begin
          beat_o.out_alpha = bdfc_pkg::ALPHA_OPAQUE;
        end
      end
    end else if (cfg_i.dst == bdfc_pkg::FMT_GRAY) begin
      beat_o.out_red = gray_val;
    end else begin
      beat_o.out_red   = avg_r;
      beat_o.out_green = avg_g;
      beat_o.out_blue  = avg_b;
      if (cfg_i.dst == bdfc_pkg::FMT_RGBA) begin
        beat_o.out_alpha = (cfg_i.src == bdfc_pkg::FMT_RGBA) ? avg_a
                                                             : bdfc_pkg::ALPHA_OPAQUE;
      end
    end
  end

endmodule

`default_nettype wire

// File: tb/bdfc_pixel_checker.sv
`default_nettype none

module bdfc_pixel_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  input  wire logic                            in_stall,
  input  wire bdfc_pkg::in_beat_t              in_data,
  input  wire logic                            out_valid,
  input  wire logic                            out_stall,
  input  wire bdfc_pkg::out_beat_t             out_data,
  input  wire logic                            cfg_valid,
  input  wire logic                            cfg_ready,
  input  wire logic [bdfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bdfc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned                          mismatches,
  output int unsigned                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import bdfc_pkg::*;

  fmt_t        src_fmt;
  fmt_t        dst_fmt;
  out_beat_t   expected_pixels [$];
  out_beat_t   want;
  int unsigned fail_total = 0;
  int unsigned beat_no = 0;

  assign mismatches = fail_total;

  function automatic out_beat_t reduce_block(input in_beat_t blk, input fmt_t s, input fmt_t d);
    logic [31:0] px [4];
    logic [9:0]  lane [4];
    int unsigned rgb_sum;
    out_beat_t   r;
    px[0] = blk.top_left;
    px[1] = blk.top_right;
    px[2] = blk.bottom_left;
    px[3] = blk.bottom_right;
    for (int k = 0; k < 4; k++) begin
      lane[k] = '0;
      for (int p = 0; p < 4; p++) begin
        lane[k] += px[p][8*k +: 8];
      end
    end
    rgb_sum = lane[0] + lane[1] + lane[2];
    r = '0;
    if (s == FMT_LAB || d == FMT_LAB) begin
      r.format_error = 1'b1;
    end else if (s == FMT_GRAY) begin
      r.out_red = lane[0][9:2];
      if (d != FMT_GRAY) begin
        r.out_green = r.out_red;
        r.out_blue  = r.out_red;
        if (d == FMT_RGBA) r.out_alpha = ALPHA_OPAQUE;
      end
    end else if (d == FMT_GRAY) begin
      // Twelve bytes sum to at most 3060, so the quotient fits in a byte.
      r.out_red = 8'(rgb_sum / 12);
    end else begin
      r.out_red   = lane[0][9:2];
      r.out_green = lane[1][9:2];
      r.out_blue  = lane[2][9:2];
      if (d == FMT_RGBA) r.out_alpha = (s == FMT_RGBA) ? lane[3][9:2] : ALPHA_OPAQUE;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: beat %0d: %s", $time, beat_no, msg);
    fail_total++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      src_fmt = FMT_RGBA;
      dst_fmt = FMT_RGBA;
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SOURCE_FORMAT) src_fmt = fmt_t'(cfg_wdata);
        else if (cfg_index == CFG_DEST_FORMAT) dst_fmt = fmt_t'(cfg_wdata);
      end
      if (in_valid && !in_stall) begin
        expected_pixels.push_back(reduce_block(in_data, src_fmt, dst_fmt));
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("result beat arrived with nothing pending");
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.out_red !== want.out_red)
            report_mismatch($sformatf("out_red %0h, predicted %0h",
                                      out_data.out_red, want.out_red));
          if (out_data.out_green !== want.out_green)
            report_mismatch($sformatf("out_green %0h, predicted %0h",
                                      out_data.out_green, want.out_green));
          if (out_data.out_blue !== want.out_blue)
            report_mismatch($sformatf("out_blue %0h, predicted %0h",
                                      out_data.out_blue, want.out_blue));
          if (out_data.out_alpha !== want.out_alpha)
            report_mismatch($sformatf("out_alpha %0h, predicted %0h",
                                      out_data.out_alpha, want.out_alpha));
          if (out_data.format_error !== want.format_error)
            report_mismatch($sformatf("format_error %0b, predicted %0b",
                                      out_data.format_error, want.format_error));
        end
        beat_no++;
      end
    end
    outstanding <= expected_pixels.size();
  end

endmodule

`default_nettype wire

// File: tb/box_downsample_2x2_format_convert_unit_tb.sv
`default_nettype none

module box_downsample_2x2_format_convert_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdfc_pkg::*;

  localparam int unsigned IDLE_PCT      = 19;
  localparam int unsigned BLOCKS_PER_FMT = 112;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned HOLD_CYCLES   = 64;
  localparam int unsigned PIPE_DRAIN    = 4;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_beat_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  logic        no_idle = 1'b0;
  logic        pressure_req = 1'b0;
  logic        pressure_done = 1'b0;

  box_downsample_2x2_format_convert_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bdfc_pixel_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Any moving beat resets the count; a long silence means the block hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("box_downsample_2x2_format_convert_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver side. One long hold-off lets the pipeline fill and stall the input.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (pressure_req && !pressure_done) begin
        pressure_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  function automatic logic [31:0] rand_pixel();
    logic [31:0] p;
    p = $urandom;
    if ($urandom_range(0, 99) < 30) begin
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(0, 2))
          0: p[8*k +: 8] = 8'h00;
          1: p[8*k +: 8] = 8'hff;
          default: ;
        endcase
      end
    end
    return p;
  endfunction

  function automatic in_beat_t rand_block();
    in_beat_t b;
    b.top_left     = rand_pixel();
    b.top_right    = rand_pixel();
    b.bottom_left  = rand_pixel();
    b.bottom_right = rand_pixel();
    return b;
  endfunction

  // Before each block the sender keeps drawing idle cycles, each with a chance
  // of IDLE_PCT percent, unless no_idle is set.
  task automatic send_block(input in_beat_t blk);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= blk;
    do @(posedge clk); while (in_stall);
  endtask

  // Waits until every predicted pixel has come out, then lets the pipe empty.
  task automatic settle();
    do @(posedge clk); while (outstanding != 0);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic program_formats(input fmt_t s, input fmt_t d);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SOURCE_FORMAT;
    cfg_wdata <= s;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_DEST_FORMAT;
    cfg_wdata <= d;
    do @(posedge clk); while (!cfg_ready);
    // Indexes past the destination format must leave both formats alone.
    if ($urandom_range(0, 1) != 0) begin
      cfg_index <= CFG_IDX_W'($urandom_range(2, 3));
      cfg_wdata <= CFG_DATA_W'($urandom);
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_corner_blocks();
    send_block('0);
    send_block('1);
    send_block('{32'h00ff00ff, 32'hff00ff00, 32'h00ff00ff, 32'hff00ff00});
    send_block('{32'hffffffff, 32'h00000000, 32'h00000000, 32'h00000000});
    in_valid <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Formats come out of reset as rgba8 to rgba8.
    send_corner_blocks();
    settle();
    program_formats(FMT_GRAY, FMT_RGBA);
    send_corner_blocks();
    settle();
    program_formats(FMT_RGB, FMT_GRAY);
    send_corner_blocks();
    settle();
    program_formats(FMT_RGBA, FMT_GRAY);
    send_corner_blocks();
    settle();
    program_formats(FMT_LAB, FMT_RGB);
    send_corner_blocks();
    settle();
    program_formats(FMT_GRAY, FMT_LAB);
    send_corner_blocks();

    for (int i = 0; i < 16; i++) begin
      settle();
      no_idle      <= (i == 5);
      pressure_req <= (i == 10);
      program_formats(fmt_t'(2'(i >> 2)), fmt_t'(2'(i)));
      for (int n = 0; n < BLOCKS_PER_FMT; n++) begin
        send_block(rand_block());
      end
      in_valid <= 1'b0;
    end

    settle();
    if (mismatches == 0) begin
      $display("box_downsample_2x2_format_convert_unit: match");
    end else begin
      $display("box_downsample_2x2_format_convert_unit: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
